@@ sv/surface_pixel_to_rgba_top_assert.svh @@
// assertion macros shared by the checker of surface_pixel_to_rgba_top
// expects clk to be visible where the macros are used
`ifndef SURFACE_PIXEL_TO_RGBA_TOP_ASSERT_SVH
`define SURFACE_PIXEL_TO_RGBA_TOP_ASSERT_SVH

// same-cycle implication
`define SP2RGBA_AST_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("sp2rgba check failed");

// next-cycle implication
`define SP2RGBA_AST_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("sp2rgba check failed");

`endif

@@ sv/sp2rgba_pkg.sv @@
// types, codes and helper functions of the surface pixel to rgba converter
// no dependencies; used by surface_pixel_to_rgba_top and its checker
`timescale 1ns / 1ps

package sp2rgba_pkg;

  localparam int IN_DATA_W   = 64;
  localparam int IN_USER_W   = 1;
  localparam int OUT_DATA_W  = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  localparam int NUM_W       = 40;
  localparam int STEP_BITS   = 8;
  localparam int DIV_STAGES  = NUM_W / STEP_BITS;
  localparam int NUM_CH      = 4;

  localparam int CH_R = 0;
  localparam int CH_G = 1;
  localparam int CH_B = 2;
  localparam int CH_A = 3;

  localparam logic [31:0] RESET_RED_MASK   = 32'h00FF_0000;
  localparam logic [31:0] RESET_GREEN_MASK = 32'h0000_FF00;
  localparam logic [31:0] RESET_BLUE_MASK  = 32'h0000_00FF;
  localparam logic [31:0] RESET_ALPHA_MASK = 32'h0000_0000;

  typedef enum logic [1:0] {
    FMT_GREY     = 2'd0,
    FMT_PALETTE  = 2'd1,
    FMT_DIRECT16 = 2'd2,
    FMT_DIRECT32 = 2'd3
  } fmt_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FORMAT    = 3'd0,
    REG_RED_MASK  = 3'd1,
    REG_GREEN_MASK = 3'd2,
    REG_BLUE_MASK = 3'd3,
    REG_ALPHA_MASK = 3'd4,
    REG_KEY_EN    = 3'd5,
    REG_KEY_VALUE = 3'd6
  } reg_idx_t;

  typedef enum logic {
    KIND_PIXEL   = 1'b0,
    KIND_PALETTE = 1'b1
  } kind_t;

  // per-mask facts worked out when the mask is written
  typedef struct packed {
    logic       zero;
    logic       wide;   // channel of 8 or more bits
    logic [4:0] shift;  // right shift applied to the masked pixel
    logic [6:0] den;    // 2^bits-1 for narrow channels
  } minfo_t;

  // one channel on its way through the scaling divider
  typedef struct packed {
    logic             is_div;
    logic [7:0]       val;
    logic [6:0]       den;
    logic [6:0]       rem;
    logic [NUM_W-1:0] num;
  } chan_t;

  typedef chan_t [NUM_CH-1:0] px_t;

  function automatic minfo_t mask_info(logic [31:0] mask);
    logic [31:0] fill;
    logic [32:0] hole;
    logic [4:0]  lsb;
    logic [5:0]  e;
    logic [5:0]  bits;
    minfo_t      mi;
    lsb = 5'd0;
    e   = 6'd32;
    for (int i = 31; i >= 0; i--) begin
      if (mask[i]) lsb = 5'(i);
    end
    // ones everywhere below the lowest set bit, so the first zero above ends the run
    fill = mask | (mask - 32'd1);
    hole = {1'b1, ~fill};
    for (int i = 32; i >= 0; i--) begin
      if (hole[i]) e = 6'(i);
    end
    bits     = e - {1'b0, lsb};
    mi.zero  = (mask == 32'd0);
    mi.wide  = (bits >= 6'd8);
    mi.shift = mi.wide ? 5'(e - 6'd8) : lsb;
    mi.den   = mi.wide ? 7'd1 : 7'((8'd1 << bits[2:0]) - 8'd1);
    return mi;
  endfunction

  function automatic chan_t direct(logic [7:0] val);
    chan_t c;
    c     = '0;
    c.val = val;
    c.den = 7'd1;
    return c;
  endfunction

  function automatic chan_t expand(logic [31:0] v, logic [31:0] mask, minfo_t mi);
    logic [31:0]      m;
    logic [NUM_W-1:0] m40;
    chan_t            c;
    m   = (v & mask) >> mi.shift;
    m40 = {8'd0, m};
    c   = direct(8'd255);
    if (!mi.zero) begin
      if (mi.wide) begin
        c.val = m[7:0];
      end else begin
        c.is_div = 1'b1;
        c.den    = mi.den;
        c.num    = (m40 << 8) - m40;  // channel * 255
      end
    end
    return c;
  endfunction

  // eight restoring division steps, msb first; the last stage leaves quotient bits 7..0
  function automatic chan_t div_step(chan_t c);
    logic [7:0] digit;
    logic [7:0] t;
    logic [7:0] q;
    logic [6:0] rem;
    chan_t      o;
    o     = c;
    digit = c.num[NUM_W-1 -: STEP_BITS];
    rem   = c.rem;
    q     = 8'd0;
    for (int i = 7; i >= 0; i--) begin
      t = {rem, digit[i]};
      if (t >= {1'b0, c.den}) begin
        q[i] = 1'b1;
        rem  = 7'(t - {1'b0, c.den});
      end else begin
        rem  = t[6:0];
      end
    end
    o.rem = rem;
    o.num = c.num << STEP_BITS;
    if (c.is_div) o.val = q;
    return o;
  endfunction

endpackage

@@ sv/surface_pixel_to_rgba_top.sv @@
// surface pixel to rgba8888 converter, top level
// converts one source pixel per cycle unless stalled; depends on sp2rgba_pkg
`timescale 1ns / 1ps
//
// usage:
//   in_*  : one word per cycle. in_tuser = kind (0 convert a pixel, 1 write a palette
//           entry). palette writes are stored and give no output word.
//   out_* : one rgba word per converted pixel, in input order.
//   cfg_* : register writes (index, data), always ready; only while the block is idle.
// throughput: one word per cycle unless stalled, palette writes included.
// path from input accept to out_tvalid: the palette ram read, the channel
//   extract register, then five steps of the narrow-channel scaling divider (8 quotient
//   bits each over a 40-bit dividend), the last of which loads the output register.
// reset: config registers take their reset values, the pipeline empties. palette
//   contents are not cleared; an entry must be written before a pixel reads it.
// stall: while out_tvalid is high and out_tready low, the whole pipe holds and
//   in_tready drops; nothing is lost or repeated.
//
module surface_pixel_to_rgba_top #(
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // pixel_value[31:0], palette_slot[39:32], entry_red[47:40], entry_green[55:48],
  // entry_blue[63:56]
  input  logic [sp2rgba_pkg::IN_DATA_W-1:0]   in_tdata,
  // kind[0]
  input  logic [sp2rgba_pkg::IN_USER_W-1:0]   in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // out_red[7:0], out_green[15:8], out_blue[23:16], out_alpha[31:24]
  output logic [sp2rgba_pkg::OUT_DATA_W-1:0]  out_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sp2rgba_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sp2rgba_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import sp2rgba_pkg::*;

  localparam int         IDX_W     = $clog2(PALETTE_ENTRIES);
  localparam logic [8:0] PAL_LIMIT = 9'(PALETTE_ENTRIES);

  // configuration
  fmt_t        fmt_r;
  logic [31:0] mask_r [NUM_CH];
  minfo_t      info_r [NUM_CH];
  logic        key_en_r;
  logic [31:0] key_val_r;

  // palette ram
  logic [23:0] pal_mem [PALETTE_ENTRIES];
  logic [23:0] pal_rd_r;

  // pipeline
  logic                  en;
  logic                  in_acc;
  logic                  pal_wr;
  logic                  s1_vld_r;
  logic [31:0]           s1_pix_r;
  px_t                   s1_px;
  logic [DIV_STAGES-1:0] d_vld_r;
  px_t                   d_px_r   [DIV_STAGES];
  px_t                   d_px_nxt [DIV_STAGES];
  px_t                   last_px;
  logic                  out_vld_r;
  logic [NUM_CH-1:0][7:0] out_px_r;

  assign en        = !out_vld_r || out_tready;
  assign in_tready = en;
  assign in_acc    = in_tvalid && en;
  assign pal_wr    = in_acc && (in_tuser[0] == KIND_PALETTE)
                     && ({1'b0, in_tdata[39:32]} < PAL_LIMIT);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r          <= FMT_DIRECT32;
      mask_r[CH_R]   <= RESET_RED_MASK;
      mask_r[CH_G]   <= RESET_GREEN_MASK;
      mask_r[CH_B]   <= RESET_BLUE_MASK;
      mask_r[CH_A]   <= RESET_ALPHA_MASK;
      info_r[CH_R]   <= mask_info(RESET_RED_MASK);
      info_r[CH_G]   <= mask_info(RESET_GREEN_MASK);
      info_r[CH_B]   <= mask_info(RESET_BLUE_MASK);
      info_r[CH_A]   <= mask_info(RESET_ALPHA_MASK);
      key_en_r       <= 1'b0;
      key_val_r      <= 32'd0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FORMAT:     fmt_r <= fmt_t'(cfg_data[1:0]);
        REG_RED_MASK: begin
          mask_r[CH_R] <= cfg_data;
          info_r[CH_R] <= mask_info(cfg_data);
        end
        REG_GREEN_MASK: begin
          mask_r[CH_G] <= cfg_data;
          info_r[CH_G] <= mask_info(cfg_data);
        end
        REG_BLUE_MASK: begin
          mask_r[CH_B] <= cfg_data;
          info_r[CH_B] <= mask_info(cfg_data);
        end
        REG_ALPHA_MASK: begin
          mask_r[CH_A] <= cfg_data;
          info_r[CH_A] <= mask_info(cfg_data);
        end
        REG_KEY_EN:     key_en_r  <= cfg_data[0];
        REG_KEY_VALUE:  key_val_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // write and lookup both happen at accept; one word per cycle so they never collide
  always_ff @(posedge clk) begin
    if (pal_wr) begin
      pal_mem[in_tdata[32 +: IDX_W]] <= {in_tdata[47:40], in_tdata[55:48], in_tdata[63:56]};
    end
    if (in_acc) begin
      pal_rd_r <= pal_mem[in_tdata[IDX_W-1:0]];
    end
  end

  always_comb begin
    logic [31:0] v;
    logic [7:0]  idx;
    logic [23:0] pe;
    logic        keyed;
    v     = (fmt_r == FMT_DIRECT16) ? {16'd0, s1_pix_r[15:0]} : s1_pix_r;
    idx   = s1_pix_r[7:0];
    pe    = ({1'b0, idx} < PAL_LIMIT) ? pal_rd_r : 24'd0;
    keyed = 1'b0;
    s1_px = '0;
    unique case (fmt_r)
      FMT_GREY: begin
        keyed       = key_en_r && ({24'd0, idx} == key_val_r);
        s1_px[CH_R] = direct(idx);
        s1_px[CH_G] = direct(idx);
        s1_px[CH_B] = direct(idx);
        s1_px[CH_A] = direct(keyed ? 8'd0 : 8'd255);
      end
      FMT_PALETTE: begin
        keyed       = key_en_r && ({24'd0, idx} == key_val_r);
        s1_px[CH_R] = direct(pe[23:16]);
        s1_px[CH_G] = direct(pe[15:8]);
        s1_px[CH_B] = direct(pe[7:0]);
        s1_px[CH_A] = direct(keyed ? 8'd0 : 8'd255);
      end
      FMT_DIRECT16, FMT_DIRECT32: begin
        keyed       = key_en_r && (v == key_val_r);
        s1_px[CH_R] = expand(v, mask_r[CH_R], info_r[CH_R]);
        s1_px[CH_G] = expand(v, mask_r[CH_G], info_r[CH_G]);
        s1_px[CH_B] = expand(v, mask_r[CH_B], info_r[CH_B]);
        // a zero alpha mask expands to 255
        s1_px[CH_A] = keyed ? direct(8'd0) : expand(v, mask_r[CH_A], info_r[CH_A]);
      end
    endcase
  end

  always_comb begin
    d_px_nxt[0] = s1_px;
    for (int k = 1; k < DIV_STAGES; k++) begin
      for (int c = 0; c < NUM_CH; c++) begin
        d_px_nxt[k][c] = div_step(d_px_r[k-1][c]);
      end
    end
    for (int c = 0; c < NUM_CH; c++) begin
      last_px[c] = div_step(d_px_r[DIV_STAGES-1][c]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      d_vld_r   <= '0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r  <= in_tvalid && (in_tuser[0] == KIND_PIXEL);
      d_vld_r   <= {d_vld_r[DIV_STAGES-2:0], s1_vld_r};
      out_vld_r <= d_vld_r[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (in_acc) s1_pix_r <= in_tdata[31:0];
      d_px_r <= d_px_nxt;
      for (int c = 0; c < NUM_CH; c++) begin
        out_px_r[c] <= last_px[c].val;
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_px_r;

endmodule

@@ sv/sp2rgba_checker.sv @@
// port-level checker for surface_pixel_to_rgba_top, attached by bind
// depends on sp2rgba_pkg and surface_pixel_to_rgba_top_assert.svh
`timescale 1ns / 1ps
`include "surface_pixel_to_rgba_top_assert.svh"

module sp2rgba_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tready,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [sp2rgba_pkg::OUT_DATA_W-1:0] out_tdata
);

  // a stalled result word stays put
  `SP2RGBA_AST_NEXT(a_out_hold, rst_n && out_tvalid && !out_tready, !rst_n || (out_tvalid && $stable(out_tdata)))

  // the pipe is empty right after reset
  `SP2RGBA_AST_NEXT(a_reset_empty, !rst_n, !out_tvalid)

  // input side only backs off when the output is stalled
  `SP2RGBA_AST_IMPLY(a_ready_on_stall, rst_n && !in_tready, out_tvalid && !out_tready)

endmodule

bind surface_pixel_to_rgba_top sp2rgba_checker u_sp2rgba_checker (.*);
